>>> src/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants for the MSB-first bit packer: the input item,
// the result item and the item kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mbp_pkg;

  // Bits in one output byte
  localparam int BYTE_BITS = 8;
  // Most bits that can stay pending between items
  localparam int PEND_BITS = 7;
  // Width of the pending bit count
  localparam int PCNT_W    = 3;

  // Item kind codes
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  // Input item
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [5:0]  code_length;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-length codes into bytes, most significant bit first; a flush
// item pushes out the remaining bits zero padded.
//
//   channel   ports                     accepted when
//   item      push, full, item          push && !full
//   result    empty, pop, result        pop && !empty
//
// The front end takes one item per cycle while its two-entry queue has room.
// The back end gives one byte per cycle while results are popped; an item's
// bytes pass through a queue slot and the back-end register before they show.
// Synchronous reset clears pending bits, queue and output; no clearing pass.
// A stalled result holds its value until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_packer #(
  parameter int MAX_CODE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire mbp_pkg::in_item_t item,
  output logic                   empty,
  input  wire logic              pop,
  output mbp_pkg::out_item_t     result
);

  localparam int ACC_W = MAX_CODE_BITS + mbp_pkg::PEND_BITS;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic             ent_valid;
  logic [ACC_W-1:0] ent_acc;
  logic [CNT_W-1:0] ent_cnt;
  logic             q_valid;
  logic [ACC_W-1:0] q_acc;
  logic [CNT_W-1:0] q_cnt;
  logic             q_take;

  mbp_front #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (push & ~full),
    .item      (item),
    .ent_valid (ent_valid),
    .ent_acc   (ent_acc),
    .ent_cnt   (ent_cnt)
  );

  mbp_queue #(.W(ACC_W + CNT_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (ent_valid),
    .wr_data  ({ent_acc, ent_cnt}),
    .rd       (q_take),
    .full     (full),
    .nonempty (q_valid),
    .rd_data  ({q_acc, q_cnt})
  );

  mbp_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_acc   (q_acc),
    .q_cnt   (q_cnt),
    .q_take  (q_take),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire

>>> src/mbp_front.sv
// ----------------------------------------------------------------------------
// mbp_front
// Accepts items, keeps the pending bits and merges each code into them.
// Every item that completes at least one byte becomes a queue entry holding
// the merged bits and their count; the back end slices bytes off it.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_front #(
  parameter  int MAX_CODE_BITS = 32,
  localparam int ACC_W         = MAX_CODE_BITS + mbp_pkg::PEND_BITS,
  localparam int CNT_W         = $clog2(ACC_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire mbp_pkg::in_item_t item,
  output logic                  ent_valid,
  output logic [ACC_W-1:0]      ent_acc,
  output logic [CNT_W-1:0]      ent_cnt
);

  logic [mbp_pkg::PEND_BITS-1:0] pending_bits, pending_bits_next;
  logic [mbp_pkg::PCNT_W-1:0]    pending_count, pending_count_next;

  logic [5:0]             len_sat;
  logic [ACC_W+31:0]      val_wide;
  logic [ACC_W-1:0]       val_ext;
  logic [ACC_W-1:0]       code_mask;
  logic [ACC_W-1:0]       acc_write;
  logic [CNT_W-1:0]       cnt_write;
  logic [7:0]             flush_byte;

  // Saturate length, mask stray value bits, append behind the pending bits
  assign len_sat   = (item.code_length > 6'(MAX_CODE_BITS)) ? 6'(MAX_CODE_BITS)
                                                              : item.code_length;
  assign val_wide  = {{ACC_W{1'b0}}, item.value};
  assign val_ext   = val_wide[ACC_W-1:0];
  assign code_mask = ~({ACC_W{1'b1}} << len_sat);
  assign acc_write = ({{(ACC_W-mbp_pkg::PEND_BITS){1'b0}}, pending_bits} << len_sat)
                   | (val_ext & code_mask);
  assign cnt_write = CNT_W'(pending_count) + CNT_W'(len_sat);

  // Pending bits left-aligned in one byte, zero padded
  assign flush_byte = 8'({1'b0, pending_bits} << (4'd8 - {1'b0, pending_count}));

  // Classify the item and work out the entry and the new pending state
  always_comb begin
    ent_valid          = 1'b0;
    ent_acc            = acc_write;
    ent_cnt            = cnt_write;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    case (item.kind)
      mbp_pkg::KIND_FLUSH: begin
        ent_acc = ACC_W'(flush_byte);
        ent_cnt = CNT_W'(mbp_pkg::BYTE_BITS);
        if (accept) begin
          ent_valid          = (pending_count != '0);
          pending_bits_next  = '0;
          pending_count_next = '0;
        end
      end
      default: begin
        if (accept) begin
          ent_valid          = (cnt_write >= CNT_W'(mbp_pkg::BYTE_BITS));
          pending_bits_next  = acc_write[mbp_pkg::PEND_BITS-1:0]
                             & ~({mbp_pkg::PEND_BITS{1'b1}} << cnt_write[2:0]);
          pending_count_next = cnt_write[2:0];
        end
      end
    endcase
  end

  // Pending state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

`default_nettype wire

>>> src/mbp_queue.sv
// ----------------------------------------------------------------------------
// mbp_queue
// Two-entry queue between front and back end. Full only when both slots
// hold entries; the oldest entry is always shown at the read side.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         rd,
  output logic              full,
  output logic              nonempty,
  output logic [W-1:0]      rd_data
);

  logic [W-1:0] slots [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   fill;

  assign full     = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign rd_data  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, wr} - {1'b0, rd};
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

>>> src/mbp_back.sv
// ----------------------------------------------------------------------------
// mbp_back
// Takes one queue entry at a time and hands out its complete bytes, oldest
// first, one per cycle while popped. The final byte of an entry is marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_back #(
  parameter  int MAX_CODE_BITS = 32,
  localparam int ACC_W         = MAX_CODE_BITS + mbp_pkg::PEND_BITS,
  localparam int CNT_W         = $clog2(ACC_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire logic [ACC_W-1:0] q_acc,
  input  wire logic [CNT_W-1:0] q_cnt,
  output logic                  q_take,
  input  wire logic             pop,
  output logic                  empty,
  output mbp_pkg::out_item_t    result
);

  logic [ACC_W-1:0] cur_acc;
  logic [CNT_W-1:0] rem;
  logic             busy;
  logic [CNT_W-1:0] shift_amt;
  logic             is_last;
  logic             done;

  // Current byte sits just above the bits still to come
  assign shift_amt       = rem - CNT_W'(mbp_pkg::BYTE_BITS);
  assign is_last         = (shift_amt < CNT_W'(mbp_pkg::BYTE_BITS));
  assign result.out_byte = 8'(cur_acc >> shift_amt);
  assign result.last     = is_last;
  assign empty           = ~busy;

  // Load a new entry when idle or when the final byte goes out
  assign done   = busy & pop & is_last;
  assign q_take = q_valid & (~busy | done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_take) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur_acc <= q_acc;
      rem     <= q_cnt;
    end else if (busy && pop) begin
      rem     <= shift_amt;
    end
  end

endmodule

`default_nettype wire

>>> src/mbp_checker.sv
// ----------------------------------------------------------------------------
// mbp_checker
// Port-level checks on the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               push,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire mbp_pkg::out_item_t result
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // A waiting result that is not popped stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

  // A full queue means the back end already holds an entry
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue full while no result shown");

  // Nothing comes out without an item taken after reset
  a_no_invent: assert property (@(posedge clk)
    rst ##1 (!push || full) |=> empty)
    else $error("result appeared with no item taken");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
